FILE: design/fmhv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhv_pkg
// Shared widths, constants, register indexes and transfer types for the
// flow meter and hysteresis valve block.
// ----------------------------------------------------------------------------
package fmhv_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int SAMPLE_W    = 12;
	localparam int LEVEL_W     = 4;
	localparam int RATE_W      = 27;
	localparam int INTERVAL_W  = 16;
	localparam int CAL_W       = 8;
	localparam int TALLY_W     = 8;
	localparam int SCALE_W     = 20;
	localparam int NUM_W       = TALLY_W + SCALE_W;
	localparam int DEN_W       = INTERVAL_W + CAL_W;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_LEVEL   = 10;

	localparam logic [SAMPLE_W+3:0]   SAMPLE_MAX = (SAMPLE_W+4)'((1 << SAMPLE_BITS) - 1);
	localparam logic [RATE_W-1:0]     RATE_MAX   = '1;
	localparam logic [SCALE_W-1:0]    RATE_SCALE = SCALE_W'(1000000);

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(1000);
	localparam logic [CAL_W-1:0]      CAL_RST      = CAL_W'(45);
	localparam logic [LEVEL_W-1:0]    OPEN_RST     = LEVEL_W'(3);
	localparam logic [LEVEL_W-1:0]    CLOSE_RST    = LEVEL_W'(2);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INTERVAL = 2'd0,
		REG_CAL      = 2'd1,
		REG_OPEN     = 2'd2,
		REG_CLOSE    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                flow_pulse;
		logic                ms_tick;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] pressure_sample;
	} in_item_t;

	typedef struct packed {
		logic               valve_on;
		logic [LEVEL_W-1:0] pressure_level;
		logic [RATE_W-1:0]  flow_rate_centi;
		logic               rate_updated;
	} out_item_t;

endpackage

FILE: design/fmhv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmhv_div
// Flow rate unit: forms tally*1e6 and elapsed*cal, then runs a restoring
// divide one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module fmhv_div import fmhv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TALLY_W-1:0]    tally,
	input  logic [INTERVAL_W-1:0] elapsed,
	input  logic [CAL_W-1:0]      cal,
	output logic                  done,
	output logic [RATE_W-1:0]     rate
);

	localparam int STEP_W = $clog2(NUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;

	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && (step_q == LAST_STEP);
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == LAST_STEP)
					run_q <= 1'b0;
				step_q <= step_q + 1'b1;
			end
		end
	end

	// num_q shifts out the dividend and collects the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(tally * RATE_SCALE);
			den_q <= DEN_W'(elapsed * cal);
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	// zero divisor yields an all-ones quotient, which saturates here too
	assign done = done_q;
	assign rate = num_q[NUM_W-1] ? RATE_MAX : num_q[RATE_W-1:0];

endmodule

FILE: design/flow_meter_and_hysteresis_valve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_meter_and_hysteresis_valve
// Pulse tally, millisecond window, scaled pressure level with hysteresis
// valve drive, and a flow rate computed when the window closes.
// An item that closes no window passes the state register and the output
// register to result transfer; one that closes a window passes operand products,
// 28 divide steps, rate capture, output register and result transfer.
// A new item is taken only in idle, once the last result has been sent.
// Reset: all counters, level, rate and valve cleared (valve closed); registers
// take their defaults.
// ----------------------------------------------------------------------------
module flow_meter_and_hysteresis_valve import fmhv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_SEND = 3'b100
	} state_t;

	state_t                state_q;

	logic [INTERVAL_W-1:0] interval_q;
	logic [CAL_W-1:0]      cal_q;
	logic [LEVEL_W-1:0]    open_q;
	logic [LEVEL_W-1:0]    close_q;

	logic [TALLY_W-1:0]    tally_q;
	logic [INTERVAL_W-1:0] elapsed_q;
	logic                  valve_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [RATE_W-1:0]     rate_q;
	logic                  upd_q;

	logic [TALLY_W-1:0]    op_tally_q;
	logic [INTERVAL_W-1:0] op_elapsed_q;
	logic                  start_q;

	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  accept;
	logic                  send;
	logic [TALLY_W-1:0]    tally_nx;
	logic [INTERVAL_W-1:0] elapsed_nx;
	logic [LEVEL_W-1:0]    level_nx;
	logic                  valve_nx;
	logic                  window;
	logic                  div_done;
	logic [RATE_W-1:0]     div_rate;

	function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W+3:0] p;
		logic [LEVEL_W-1:0]  n;
		p = (SAMPLE_W+4)'(s) * (SAMPLE_W+4)'(MAX_LEVEL);
		n = '0;
		for (int k = 1; k <= MAX_LEVEL; k++) begin
			if (p >= (SAMPLE_W+4)'(k * SAMPLE_MAX))
				n = n + 1'b1;
		end
		return n;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign send     = (state_q == ST_SEND) && (!out_valid_q || out_ready);

	always_comb begin
		tally_nx   = in_data.flow_pulse ? tally_q + 1'b1 : tally_q;
		elapsed_nx = (in_data.ms_tick && elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		level_nx   = level_q;
		valve_nx   = valve_q;
		if (in_data.sample_valid) begin
			level_nx = level_of(in_data.pressure_sample);
			if (!valve_nx && level_nx >= open_q)
				valve_nx = 1'b1;
			if (valve_nx && level_nx <= close_q)
				valve_nx = 1'b0;
		end
		window = elapsed_nx > interval_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			cal_q      <= CAL_RST;
			open_q     <= OPEN_RST;
			close_q    <= CLOSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_INTERVAL: interval_q <= cfg_wdata[INTERVAL_W-1:0];
				REG_CAL:      cal_q      <= cfg_wdata[CAL_W-1:0];
				REG_OPEN:     open_q     <= cfg_wdata[LEVEL_W-1:0];
				REG_CLOSE:    close_q    <= cfg_wdata[LEVEL_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			elapsed_q   <= '0;
			valve_q     <= 1'b0;
			level_q     <= '0;
			rate_q      <= '0;
			upd_q       <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept && window;
			if (send)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valve_q <= valve_nx;
						level_q <= level_nx;
						upd_q   <= window;
						if (window) begin
							tally_q   <= '0;
							elapsed_q <= '0;
							state_q   <= ST_CALC;
						end else begin
							tally_q   <= tally_nx;
							elapsed_q <= elapsed_nx;
							state_q   <= ST_SEND;
						end
					end
				end
				ST_CALC: begin
					if (div_done) begin
						rate_q  <= div_rate;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (send)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && window) begin
			op_tally_q   <= tally_nx;
			op_elapsed_q <= elapsed_nx;
		end
		if (send) begin
			out_q.valve_on        <= valve_q;
			out_q.pressure_level  <= level_q;
			out_q.flow_rate_centi <= rate_q;
			out_q.rate_updated    <= upd_q;
		end
	end

	fmhv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.tally   (op_tally_q),
		.elapsed (op_elapsed_q),
		.cal     (cal_q),
		.done    (div_done),
		.rate    (div_rate)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
